[rtl/tlc_pkg.sv]
// Shared types, register indexes and format codes for the texture layout calculator.
`timescale 1ns / 1ps

package tlc_pkg;

	localparam logic [1:0] REG_MIN_BLOCK_PITCH = 2'd0;
	localparam logic [1:0] REG_NPOT_OK_COMPRESSED = 2'd1;
	localparam logic [1:0] REG_NPOT_OK_PLAIN = 2'd2;
	localparam logic [1:0] REG_MAX_TEX_SIZE = 2'd3;

	localparam logic [2:0] FMT_DXT1 = 3'd0;
	localparam logic [2:0] FMT_DXT3 = 3'd1;
	localparam logic [2:0] FMT_DXT5 = 3'd2;
	localparam logic [2:0] FMT_DXT5_YCOCG = 3'd3;
	localparam logic [2:0] FMT_A8 = 3'd4;
	localparam logic [2:0] FMT_RGB8 = 3'd5;
	localparam logic [2:0] FMT_RGBA8 = 3'd6;
	localparam logic [2:0] FMT_ARGB8 = 3'd7;

	localparam logic [17:0] PITCH_MAX = 18'd262140;

	typedef struct packed {
		logic [15:0] img_width;
		logic [15:0] img_height;
		logic [2:0]  pix_format;
	} req_t;

	typedef struct packed {
		logic [15:0] tex_width;
		logic [15:0] tex_height;
		logic [15:0] out_img_width;
		logic [15:0] out_img_height;
		logic [17:0] row_pitch;
		logic [15:0] row_total;
		logic [4:0]  unit_bytes;
		logic [33:0] buffer_bytes;
	} rsp_t;

	typedef struct packed {
		logic [15:0] min_block_pitch;
		logic        npot_ok_compressed;
		logic        npot_ok_plain;
		logic [15:0] max_tex_size;
	} cfg_t;

	typedef struct packed {
		logic [15:0] tex_width;
		logic [15:0] tex_height;
		logic [15:0] img_width;
		logic [15:0] img_height;
		logic [2:0]  pix_format;
	} geom_t;

	typedef struct packed {
		logic [17:0] row_pitch;
		logic [15:0] row_total;
		logic [4:0]  unit_bytes;
	} pitch_t;

	function automatic logic is_block(input logic [2:0] fmt);
		return (fmt == tlc_pkg::FMT_DXT1) || (fmt == tlc_pkg::FMT_DXT3) ||
			(fmt == tlc_pkg::FMT_DXT5) || (fmt == tlc_pkg::FMT_DXT5_YCOCG);
	endfunction

endpackage

[rtl/tlc_size.sv]
// Texture size logic: minimum block pitch growth, power-of-two padding, alignment and clamping.
`timescale 1ns / 1ps

module tlc_size (
	input  tlc_pkg::req_t  req,
	input  tlc_pkg::cfg_t  cfg,
	output tlc_pkg::geom_t geom
);

	function automatic logic [17:0] pad_pow2(input logic [17:0] v);
		logic [17:0] x;
		x = v - 18'd1;
		x = x | (x >> 1);
		x = x | (x >> 2);
		x = x | (x >> 4);
		x = x | (x >> 8);
		x = x | (x >> 16);
		return x + 18'd1;
	endfunction

	logic        blk;
	logic        dxt1;
	logic        npot;
	logic [16:0] wsum;
	logic [14:0] quads;
	logic [18:0] p0;
	logic [15:0] diff;
	logic [16:0] step_sum;
	logic [15:0] grow;
	logic [17:0] tw0;
	logic [17:0] tw1;
	logic [17:0] th1;
	logic [17:0] tw2;
	logic [17:0] th2;
	logic [17:0] max18;

	always_comb begin
		blk = tlc_pkg::is_block(req.pix_format);
		dxt1 = (req.pix_format == tlc_pkg::FMT_DXT1);
		wsum = {1'b0, req.img_width} + 17'd3;
		quads = wsum[16:2];
		p0 = dxt1 ? {1'b0, quads, 3'b000} : {quads, 4'b0000};
		diff = cfg.min_block_pitch - p0[15:0];
		step_sum = '0;
		grow = '0;
		if (blk && (p0 < {3'b000, cfg.min_block_pitch})) begin
			if (dxt1) begin
				step_sum = {1'b0, diff} + 17'd15;
				grow = {step_sum[16:4], 3'b000};
			end else begin
				step_sum = {1'b0, diff} + 17'd63;
				grow = {1'b0, step_sum[16:6], 4'b0000};
			end
		end
		tw0 = {2'b00, req.img_width} + {2'b00, grow};

		npot = blk ? cfg.npot_ok_compressed : cfg.npot_ok_plain;
		tw1 = npot ? tw0 : pad_pow2(tw0);
		th1 = npot ? {2'b00, req.img_height} : pad_pow2({2'b00, req.img_height});

		if (blk) begin
			tw2 = (tw1 + 18'd3) & 18'h3FFFC;
			th2 = (th1 + 18'd3) & 18'h3FFFC;
		end else begin
			tw2 = (tw1 + 18'd15) & 18'h3FFF0;
			th2 = th1;
		end

		max18 = {2'b00, cfg.max_tex_size};
		geom.tex_width = (tw2 > max18) ? cfg.max_tex_size : tw2[15:0];
		geom.tex_height = (th2 > max18) ? cfg.max_tex_size : th2[15:0];
		geom.img_width = (req.img_width > geom.tex_width) ? geom.tex_width : req.img_width;
		geom.img_height = (req.img_height > geom.tex_height) ? geom.tex_height :
			req.img_height;
		geom.pix_format = req.pix_format;
	end

endmodule

[rtl/tlc_pitch.sv]
// Row pitch, row count and unit size from the final texture size and pixel format.
`timescale 1ns / 1ps

module tlc_pitch (
	input  tlc_pkg::geom_t  geom,
	output tlc_pkg::pitch_t pitch
);

	logic [16:0] wsum;
	logic [14:0] wquads;
	logic [16:0] hsum;
	logic [17:0] w1;
	logic [17:0] w3;
	logic [18:0] p19;

	always_comb begin
		wsum = {1'b0, geom.tex_width} + 17'd3;
		wquads = wsum[16:2];
		hsum = {1'b0, geom.tex_height} + 17'd3;
		w1 = {2'b00, geom.tex_width} + 18'd1;
		w3 = w1 + {w1[16:0], 1'b0};
		unique case (geom.pix_format)
			tlc_pkg::FMT_DXT1: begin
				p19 = {1'b0, wquads, 3'b000};
				pitch.unit_bytes = 5'd8;
			end
			tlc_pkg::FMT_DXT3, tlc_pkg::FMT_DXT5, tlc_pkg::FMT_DXT5_YCOCG: begin
				p19 = {wquads, 4'b0000};
				pitch.unit_bytes = 5'd16;
			end
			tlc_pkg::FMT_A8: begin
				p19 = {3'b000, geom.tex_width};
				pitch.unit_bytes = 5'd1;
			end
			tlc_pkg::FMT_RGB8: begin
				p19 = {1'b0, w3 & 18'h3FFFC};
				pitch.unit_bytes = 5'd4;
			end
			tlc_pkg::FMT_RGBA8, tlc_pkg::FMT_ARGB8: begin
				p19 = {1'b0, geom.tex_width, 2'b00};
				pitch.unit_bytes = 5'd4;
			end
			default: begin
				p19 = '0;
				pitch.unit_bytes = 5'd4;
			end
		endcase
		pitch.row_pitch = (p19 > {1'b0, tlc_pkg::PITCH_MAX}) ? tlc_pkg::PITCH_MAX : p19[17:0];
		pitch.row_total = tlc_pkg::is_block(geom.pix_format) ? {1'b0, hsum[16:2]} :
			geom.tex_height;
	end

endmodule

[rtl/texture_layout_calc_core.sv]
// Top level of the texture layout calculator: configuration registers and a three-stage pipeline.
// A request is registered in req_s1, then as geom_s2, then in the result register that drives rsp.
// Throughput: one request per cycle while rsp_ready holds; the sizing stage, the pitch stage with its 18 by 16 bit
// multiply and the result register each hold one request, and each advances when it is empty or the next one advances.
// Reset clears the stage valid bits and loads the configuration defaults: minimum block pitch 0,
// both power-of-two flags set and a maximum texture size of 4096.
`timescale 1ns / 1ps

module texture_layout_calc_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_addr,
	input  logic [15:0]    cfg_wdata,
	input  logic           req_valid,
	output logic           req_ready,
	input  tlc_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tlc_pkg::rsp_t  rsp
);

	tlc_pkg::cfg_t   cfg_q;
	tlc_pkg::req_t   req_s1;
	logic            valid_s1;
	tlc_pkg::geom_t  geom_s2;
	logic            valid_s2;
	tlc_pkg::rsp_t   rsp_q;
	logic            valid_q;
	tlc_pkg::geom_t  geom;
	tlc_pkg::pitch_t pitch;
	tlc_pkg::rsp_t   rsp_next;
	logic            adv_q;
	logic            adv_s2;
	logic            adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_block_pitch <= 16'd0;
			cfg_q.npot_ok_compressed <= 1'b1;
			cfg_q.npot_ok_plain <= 1'b1;
			cfg_q.max_tex_size <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tlc_pkg::REG_MIN_BLOCK_PITCH: cfg_q.min_block_pitch <= cfg_wdata;
				tlc_pkg::REG_NPOT_OK_COMPRESSED: cfg_q.npot_ok_compressed <= cfg_wdata[0];
				tlc_pkg::REG_NPOT_OK_PLAIN: cfg_q.npot_ok_plain <= cfg_wdata[0];
				tlc_pkg::REG_MAX_TEX_SIZE: cfg_q.max_tex_size <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign adv_q = !valid_q || rsp_ready;
	assign adv_s2 = !valid_s2 || adv_q;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign req_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_q) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (adv_s2 && valid_s1) begin
			geom_s2 <= geom;
		end
		if (adv_q && valid_s2) begin
			rsp_q <= rsp_next;
		end
	end

	tlc_size u_size (
		.req  (req_s1),
		.cfg  (cfg_q),
		.geom (geom)
	);

	tlc_pitch u_pitch (
		.geom  (geom_s2),
		.pitch (pitch)
	);

	always_comb begin
		rsp_next.tex_width = geom_s2.tex_width;
		rsp_next.tex_height = geom_s2.tex_height;
		rsp_next.out_img_width = geom_s2.img_width;
		rsp_next.out_img_height = geom_s2.img_height;
		rsp_next.row_pitch = pitch.row_pitch;
		rsp_next.row_total = pitch.row_total;
		rsp_next.unit_bytes = pitch.unit_bytes;
		rsp_next.buffer_bytes = {16'd0, pitch.row_pitch} * {18'd0, pitch.row_total};
	end

	assign rsp_valid = valid_q;
	assign rsp = rsp_q;

endmodule

[sim/tb.sv]
// Self-checking testbench for the texture layout calculator, with directed and random requests.
`timescale 1ns / 1ps

module tb;
	import tlc_pkg::*;

	localparam int LIMIT = 200000;
	localparam int PHASES = 10;
	localparam int PER_PHASE = 115;

	localparam cfg_t CFG_RESET = '{16'd0, 1'b1, 1'b1, 16'd4096};
	localparam cfg_t CFG_GROW = '{16'hFFFF, 1'b1, 1'b1, 16'hFFFF};
	localparam cfg_t CFG_POW2 = '{16'd0, 1'b0, 1'b0, 16'd4096};
	localparam cfg_t CFG_ZERO = '{16'd0, 1'b1, 1'b1, 16'd0};
	localparam cfg_t CFG_WIDE = '{16'd0, 1'b1, 1'b1, 16'hFFFF};
	localparam cfg_t CFG_MIXED = '{16'd1000, 1'b0, 1'b1, 16'd2048};

	typedef struct packed {
		cfg_t regs;
		req_t rq;
		logic known;
		rsp_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = REG_MIN_BLOCK_PITCH;
	logic [15:0] cfg_wdata = 16'd0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	cfg_t regs = CFG_RESET;
	rsp_t layouts_due[$];
	int mismatches = 0;
	int cycles = 0;
	bit steady = 1'b0;

	script_row_t script [0:24] = '{
		'{CFG_RESET, '{16'd0, 16'd0, FMT_DXT1}, 1'b1,
			'{16'd0, 16'd0, 16'd0, 16'd0, 18'd0, 16'd0, 5'd8, 34'd0}},
		'{CFG_RESET, '{16'd100, 16'd50, FMT_A8}, 1'b1,
			'{16'd112, 16'd50, 16'd100, 16'd50, 18'd112, 16'd50, 5'd1, 34'd5600}},
		'{CFG_RESET, '{16'hFFFF, 16'hFFFF, FMT_RGBA8}, 1'b1,
			'{16'd4096, 16'd4096, 16'd4096, 16'd4096, 18'd16384, 16'd4096, 5'd4,
				34'd67108864}},
		'{CFG_RESET, '{16'd1, 16'd1, FMT_DXT1}, 1'b0, '0},
		'{CFG_RESET, '{16'd13, 16'd7, FMT_DXT3}, 1'b0, '0},
		'{CFG_RESET, '{16'd30, 16'd30, FMT_DXT5}, 1'b0, '0},
		'{CFG_RESET, '{16'd31, 16'd9, FMT_DXT5_YCOCG}, 1'b0, '0},
		'{CFG_RESET, '{16'd17, 16'd3, FMT_RGB8}, 1'b0, '0},
		'{CFG_RESET, '{16'd33, 16'd5, FMT_ARGB8}, 1'b0, '0},
		'{CFG_RESET, '{16'hFFFF, 16'd0, FMT_A8}, 1'b0, '0},
		'{CFG_GROW, '{16'd1, 16'd1, FMT_DXT1}, 1'b0, '0},
		'{CFG_GROW, '{16'd0, 16'd2, FMT_DXT5}, 1'b0, '0},
		'{CFG_GROW, '{16'hFFFF, 16'hFFFF, FMT_DXT3}, 1'b0, '0},
		'{CFG_POW2, '{16'd0, 16'd0, FMT_RGB8}, 1'b0, '0},
		'{CFG_POW2, '{16'd100, 16'd300, FMT_DXT1}, 1'b0, '0},
		'{CFG_POW2, '{16'd1025, 16'd3, FMT_RGBA8}, 1'b0, '0},
		'{CFG_POW2, '{16'hFFFF, 16'hFFFF, FMT_DXT5}, 1'b0, '0},
		'{CFG_ZERO, '{16'd1234, 16'd777, FMT_DXT5}, 1'b1,
			'{16'd0, 16'd0, 16'd0, 16'd0, 18'd0, 16'd0, 5'd16, 34'd0}},
		'{CFG_ZERO, '{16'd0, 16'd0, FMT_A8}, 1'b0, '0},
		'{CFG_WIDE, '{16'd65533, 16'd4, FMT_DXT3}, 1'b1,
			'{16'hFFFF, 16'd4, 16'd65533, 16'd4, 18'd262140, 16'd1, 5'd16, 34'd262140}},
		'{CFG_WIDE, '{16'hFFFF, 16'hFFFF, FMT_DXT5_YCOCG}, 1'b0, '0},
		'{CFG_WIDE, '{16'hFFFF, 16'hFFFF, FMT_RGB8}, 1'b0, '0},
		'{CFG_WIDE, '{16'hFFFF, 16'hFFFF, FMT_ARGB8}, 1'b0, '0},
		'{CFG_MIXED, '{16'd5, 16'd5, FMT_DXT1}, 1'b0, '0},
		'{CFG_MIXED, '{16'd5, 16'd5, FMT_A8}, 1'b0, '0}
	};

	texture_layout_calc_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] bytes_per_row(input logic [2:0] fmt, input logic [31:0] w);
		case (fmt)
			FMT_DXT1: return ((w + 32'd3) / 32'd4) * 32'd8;
			FMT_DXT3, FMT_DXT5, FMT_DXT5_YCOCG: return ((w + 32'd3) / 32'd4) * 32'd16;
			FMT_A8: return w;
			FMT_RGB8: return (((w + 32'd1) * 32'd3) / 32'd4) * 32'd4;
			default: return w * 32'd4;
		endcase
	endfunction

	function automatic logic [31:0] pow2_ceil(input logic [31:0] v);
		logic [31:0] x;
		x = v - 32'd1;
		x = x | (x >> 1);
		x = x | (x >> 2);
		x = x | (x >> 4);
		x = x | (x >> 8);
		x = x | (x >> 16);
		return x + 32'd1;
	endfunction

	function automatic rsp_t layout_of(input req_t r, input cfg_t c);
		logic blk;
		logic npot;
		logic [31:0] iw, ih, tw, th, unit, p0, stride, steps, pitch, rows, cap;
		logic [63:0] total;
		rsp_t o;
		blk = (r.pix_format <= FMT_DXT5_YCOCG);
		iw = {16'd0, r.img_width};
		ih = {16'd0, r.img_height};
		tw = iw;
		th = ih;
		cap = {16'd0, c.max_tex_size};
		case (r.pix_format)
			FMT_DXT1: unit = 32'd8;
			FMT_DXT3, FMT_DXT5, FMT_DXT5_YCOCG: unit = 32'd16;
			FMT_A8: unit = 32'd1;
			default: unit = 32'd4;
		endcase
		if (blk) begin
			p0 = bytes_per_row(r.pix_format, tw);
			if (p0 < {16'd0, c.min_block_pitch}) begin
				stride = (r.pix_format == FMT_DXT1) ? 32'd16 : 32'd64;
				steps = ({16'd0, c.min_block_pitch} - p0 + stride - 32'd1) / stride;
				tw = tw + steps * unit;
			end
		end
		npot = blk ? c.npot_ok_compressed : c.npot_ok_plain;
		if (!npot) begin
			tw = pow2_ceil(tw);
			th = pow2_ceil(th);
		end
		if (blk) begin
			tw = ((tw + 32'd3) / 32'd4) * 32'd4;
			th = ((th + 32'd3) / 32'd4) * 32'd4;
		end else begin
			tw = ((tw + 32'd15) / 32'd16) * 32'd16;
		end
		if (tw > cap) tw = cap;
		if (th > cap) th = cap;
		if (iw > tw) iw = tw;
		if (ih > th) ih = th;
		pitch = bytes_per_row(r.pix_format, tw);
		if (pitch > {14'd0, PITCH_MAX}) pitch = {14'd0, PITCH_MAX};
		rows = blk ? (th + 32'd3) / 32'd4 : th;
		total = {32'd0, pitch} * {32'd0, rows};
		o.tex_width = tw[15:0];
		o.tex_height = th[15:0];
		o.out_img_width = iw[15:0];
		o.out_img_height = ih[15:0];
		o.row_pitch = pitch[17:0];
		o.row_total = rows[15:0];
		o.unit_bytes = unit[4:0];
		o.buffer_bytes = total[33:0];
		return o;
	endfunction

	function automatic logic [15:0] random_size();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(0, 64));
			6, 7: return 16'($urandom_range(0, 4096));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic put_reg(input logic [1:0] addr, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	task automatic write_regs(input cfg_t c);
		req_valid <= 1'b0;
		while (layouts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		put_reg(REG_MIN_BLOCK_PITCH, c.min_block_pitch);
		put_reg(REG_NPOT_OK_COMPRESSED, {15'd0, c.npot_ok_compressed});
		put_reg(REG_NPOT_OK_PLAIN, {15'd0, c.npot_ok_plain});
		put_reg(REG_MAX_TEX_SIZE, c.max_tex_size);
		cfg_we <= 1'b0;
		regs = c;
	endtask

	task automatic send(input req_t r, input logic known, input rsp_t want);
		while (!steady && $urandom_range(0, 99) < 32) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		layouts_due.push_back(known ? want : layout_of(r, regs));
	endtask

	task automatic check_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin : result_monitor
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (layouts_due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %p", $time, rsp);
				mismatches++;
			end else begin
				want = layouts_due.pop_front();
				check_field("tex_width", want.tex_width, rsp.tex_width);
				check_field("tex_height", want.tex_height, rsp.tex_height);
				check_field("out_img_width", want.out_img_width, rsp.out_img_width);
				check_field("out_img_height", want.out_img_height, rsp.out_img_height);
				check_field("row_pitch", want.row_pitch, rsp.row_pitch);
				check_field("row_total", want.row_total, rsp.row_total);
				check_field("unit_bytes", want.unit_bytes, rsp.unit_bytes);
				check_field("buffer_bytes", want.buffer_bytes, rsp.buffer_bytes);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t c;
		req_t r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].regs != regs) write_regs(script[i].regs);
			send(script[i].rq, script[i].known, script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: c = '{16'hFFFF, 1'b0, 1'b0, 16'hFFFF};
				1: c = '{16'd0, 1'b1, 1'b1, 16'd0};
				default: begin
					case ($urandom_range(0, 3))
						0: c.min_block_pitch = 16'd0;
						1: c.min_block_pitch = 16'hFFFF;
						2: c.min_block_pitch = 16'($urandom_range(0, 2048));
						default: c.min_block_pitch = 16'($urandom_range(0, 65535));
					endcase
					c.npot_ok_compressed = 1'($urandom_range(0, 1));
					c.npot_ok_plain = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 4))
						0: c.max_tex_size = 16'hFFFF;
						1: c.max_tex_size = 16'd4096;
						2: c.max_tex_size = 16'($urandom_range(0, 512));
						default: c.max_tex_size = 16'($urandom_range(0, 65535));
					endcase
				end
			endcase
			write_regs(c);
			steady = (p == 4) || (p == 5);
			for (int k = 0; k < PER_PHASE; k++) begin
				r.img_width = random_size();
				r.img_height = random_size();
				r.pix_format = 3'($urandom_range(0, 7));
				send(r, 1'b0, '0);
			end
		end

		req_valid <= 1'b0;
		steady = 1'b0;
		while (layouts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
rtl/tlc_pkg.sv
rtl/tlc_size.sv
rtl/tlc_pitch.sv
rtl/texture_layout_calc_core.sv
sim/tb.sv
